// File: design/prf_pkg.sv
`timescale 1ns / 1ps

package prf_pkg;

   localparam int CH_COUNT = 4;

   localparam logic [1:0] CMD_RAMP_RGBA = 2'd0;
   localparam logic [1:0] CMD_RAMP_RGB  = 2'd1;
   localparam logic [1:0] CMD_RAMP_ONE  = 2'd2;
   localparam logic [1:0] CMD_READ      = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] first_index;
      logic [7:0] last_index;
      logic [1:0] channel;
      logic [7:0] first_ch0;
      logic [7:0] first_ch1;
      logic [7:0] first_ch2;
      logic [7:0] first_ch3;
      logic [7:0] last_ch0;
      logic [7:0] last_ch1;
      logic [7:0] last_ch2;
      logic [7:0] last_ch3;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rsp_type;

endpackage

// File: design/palette_ramp_fill_unit.sv
`timescale 1ns / 1ps

// RGBA palette with gradient fill. The palette holds min(PALETTE_ENTRIES, 256) entries of
// four 8-bit channels in a single-port-write, registered-read memory. After reset the block
// stays busy while it clears the memory to zero. A read command keeps busy high in its read
// state; its result appears with rsp_strobe for exactly one cycle, passing through the memory
// read register and then the result register, and the receiver cannot stall it. A ramp over
// n = |last - first| steps keeps busy high through a per-channel shift-subtract divider that
// finds the step size, a setup state, one read-modify-write of the memory per entry, and a
// drain state that retires the last write; a ramp with equal indices skips divider and setup.
module palette_ramp_fill_unit #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  prf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output prf_pkg::rsp_type rsp_data
);
   import prf_pkg::*;

   localparam int MEM_DEPTH = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_PREP,
      ST_RAMP,
      ST_DRAIN,
      ST_READ
   } state_type;

   state_type state_ff;

   logic [31:0] palette_mem [MEM_DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] mem_raddr;
   logic [AW-1:0] mem_waddr;
   logic [31:0] mem_wdata;
   logic          mem_we;

   logic [AW-1:0] clr_addr_ff;
   logic [7:0]    idx_ff;
   logic          up_ff;
   logic [7:0]    cnt_ff;
   logic [7:0]    n_ff;
   logic [3:0]    mask_ff;
   logic          rd_oob_ff;
   logic [2:0]    dv_cnt_ff;

   logic          wr_en_ff;
   logic [7:0]    wr_idx_ff;
   logic [7:0]    wr_val_ff [CH_COUNT];

   logic [7:0]       val_ff    [CH_COUNT];
   logic [7:0]       rem_ff    [CH_COUNT];
   logic signed [8:0] qd_ff    [CH_COUNT];
   logic [7:0]       rd_ff     [CH_COUNT];
   logic [7:0]       dv_rem_ff [CH_COUNT];
   logic [7:0]       dv_quo_ff [CH_COUNT];
   logic             neg_ff    [CH_COUNT];

   logic [7:0]       val_in    [CH_COUNT];
   logic [7:0]       rem_in    [CH_COUNT];
   logic [8:0]       qd_in     [CH_COUNT];
   logic [7:0]       rd_in     [CH_COUNT];
   logic [7:0]       dv_rem_in [CH_COUNT];
   logic [7:0]       dv_quo_in [CH_COUNT];

   logic [7:0]  first_val [CH_COUNT];
   logic [7:0]  last_val  [CH_COUNT];
   logic [7:0]  abs_diff  [CH_COUNT];
   logic        diff_neg  [CH_COUNT];
   logic [7:0]  req_n;
   logic [3:0]  req_mask;
   logic        accept;

   logic [31:0] rsp_word_ff;
   logic        rsp_valid_ff;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      logic sel_one;
      sel_one = (req_data.command == CMD_RAMP_ONE);
      first_val[0] = req_data.first_ch0;
      first_val[1] = sel_one ? req_data.first_ch0 : req_data.first_ch1;
      first_val[2] = sel_one ? req_data.first_ch0 : req_data.first_ch2;
      first_val[3] = sel_one ? req_data.first_ch0 : req_data.first_ch3;
      last_val[0]  = req_data.last_ch0;
      last_val[1]  = sel_one ? req_data.last_ch0 : req_data.last_ch1;
      last_val[2]  = sel_one ? req_data.last_ch0 : req_data.last_ch2;
      last_val[3]  = sel_one ? req_data.last_ch0 : req_data.last_ch3;
   end

   always_comb begin
      logic [8:0] diff;
      for (int c = 0; c < CH_COUNT; c++) begin
         diff        = {1'b0, last_val[c]} - {1'b0, first_val[c]};
         diff_neg[c] = diff[8];
         abs_diff[c] = diff[8] ? 8'(-diff) : diff[7:0];
      end
   end

   always_comb begin
      if (req_data.last_index > req_data.first_index) begin
         req_n = req_data.last_index - req_data.first_index;
      end else begin
         req_n = req_data.first_index - req_data.last_index;
      end
      case (req_data.command)
         CMD_RAMP_RGBA: req_mask = 4'b1111;
         CMD_RAMP_RGB:  req_mask = 4'b0111;
         CMD_RAMP_ONE:  req_mask = 4'(4'b0001 << req_data.channel);
         default:       req_mask = 4'b0000;
      endcase
   end

   always_comb begin
      logic [8:0] t;
      logic       ge;
      for (int c = 0; c < CH_COUNT; c++) begin
         t            = {dv_rem_ff[c], dv_quo_ff[c][7]};
         ge           = (t >= {1'b0, n_ff});
         dv_rem_in[c] = ge ? 8'(t - {1'b0, n_ff}) : t[7:0];
         dv_quo_in[c] = {dv_quo_ff[c][6:0], ge};
      end
   end

   always_comb begin
      logic r_zero;
      for (int c = 0; c < CH_COUNT; c++) begin
         r_zero = (dv_rem_ff[c] == 8'd0);
         if (neg_ff[c]) begin
            qd_in[c] = ~{1'b0, dv_quo_ff[c]} + {8'd0, r_zero};
            rd_in[c] = r_zero ? 8'd0 : n_ff - dv_rem_ff[c];
         end else begin
            qd_in[c] = {1'b0, dv_quo_ff[c]};
            rd_in[c] = dv_rem_ff[c];
         end
      end
   end

   always_comb begin
      logic [8:0] sum;
      logic       carry;
      for (int c = 0; c < CH_COUNT; c++) begin
         sum       = {1'b0, rem_ff[c]} + {1'b0, rd_ff[c]};
         carry     = (sum >= {1'b0, n_ff});
         rem_in[c] = carry ? 8'(sum - {1'b0, n_ff}) : sum[7:0];
         val_in[c] = 8'({2'b00, val_ff[c]} + {qd_ff[c][8], qd_ff[c]} + {9'd0, carry});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == AW'(MEM_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (req_data.command == CMD_READ) begin
                     rd_oob_ff <= !(int'(req_data.first_index) < PALETTE_ENTRIES);
                     state_ff  <= ST_READ;
                  end else begin
                     idx_ff    <= req_data.first_index;
                     up_ff     <= (req_data.last_index > req_data.first_index);
                     cnt_ff    <= req_n;
                     n_ff      <= req_n;
                     mask_ff   <= req_mask;
                     dv_cnt_ff <= '0;
                     for (int c = 0; c < CH_COUNT; c++) begin
                        val_ff[c]    <= (req_n == 8'd0) ? last_val[c] : first_val[c];
                        rem_ff[c]    <= '0;
                        dv_rem_ff[c] <= '0;
                        dv_quo_ff[c] <= abs_diff[c];
                        neg_ff[c]    <= diff_neg[c];
                     end
                     state_ff <= (req_n == 8'd0) ? ST_RAMP : ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               for (int c = 0; c < CH_COUNT; c++) begin
                  dv_rem_ff[c] <= dv_rem_in[c];
                  dv_quo_ff[c] <= dv_quo_in[c];
               end
               dv_cnt_ff <= dv_cnt_ff + 1'b1;
               if (dv_cnt_ff == 3'd7) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               for (int c = 0; c < CH_COUNT; c++) begin
                  qd_ff[c] <= qd_in[c];
                  rd_ff[c] <= rd_in[c];
               end
               state_ff <= ST_RAMP;
            end
            ST_RAMP: begin
               wr_en_ff  <= (int'(idx_ff) < PALETTE_ENTRIES);
               wr_idx_ff <= idx_ff;
               for (int c = 0; c < CH_COUNT; c++) begin
                  wr_val_ff[c] <= val_ff[c];
                  val_ff[c]    <= val_in[c];
                  rem_ff[c]    <= rem_in[c];
               end
               idx_ff <= up_ff ? idx_ff + 8'd1 : idx_ff - 8'd1;
               cnt_ff <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd0) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_IDLE;
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_word_ff  <= rd_oob_ff ? 32'd0 : rd_data_ff;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      mem_raddr = (state_ff == ST_IDLE) ? req_data.first_index[AW-1:0] : idx_ff[AW-1:0];
      mem_we    = (state_ff == ST_CLEAR) || wr_en_ff;
      mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : wr_idx_ff[AW-1:0];
      for (int c = 0; c < CH_COUNT; c++) begin
         mem_wdata[8*c +: 8] = mask_ff[c] ? wr_val_ff[c] : rd_data_ff[8*c +: 8];
      end
      if (state_ff == ST_CLEAR) begin
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= palette_mem[mem_raddr];
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_data.red   = rsp_word_ff[7:0];
   assign rsp_data.green = rsp_word_ff[15:8];
   assign rsp_data.blue  = rsp_word_ff[23:16];
   assign rsp_data.alpha = rsp_word_ff[31:24];

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe held for more than one cycle.");

   a_read_latency : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.command == CMD_READ)) |-> ##2 rsp_strobe)
      else $error("Read transfer did not produce a result two cycles later.");

   a_write_in_ramp : assert property (@(posedge clock) disable iff (reset)
      wr_en_ff |-> ((state_ff == ST_RAMP) || (state_ff == ST_DRAIN)))
      else $error("Palette write pending outside a ramp.");

   a_no_result_on_ramp : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.command != CMD_READ)) |-> ##2 !rsp_strobe)
      else $error("Ramp command produced a result.");

endmodule
